>>> hdl/bmv_pkg.sv
// Shared types, constants and fp32 arithmetic helpers for the bf16 matrix-vector unit.
package bmv_pkg;

	// Input command codes.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_WEIGHT = 1'b1;

	// Configuration register indexes.
	localparam logic REG_ROW_LENGTH = 1'b0;
	localparam logic REG_ROW_COUNT  = 1'b1;

	localparam logic [13:0] ROW_LENGTH_RESET = 14'd1024;
	localparam logic [18:0] ROW_COUNT_RESET  = 19'd1024;
	localparam logic [18:0] ROW_COUNT_MAX    = 19'd262144;
	localparam int          WIDEN_SHIFT      = 16;
	localparam logic [31:0] QUIET_NAN        = 32'h7FC0_0000;

	// Result queue.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	// Row bookkeeping that travels with each weight down the pipeline.
	typedef struct packed {
		logic        first;
		logic        row_end;
		logic        last;
		logic [17:0] row;
	} tag_t;

	// One result as it sits in the queue.
	typedef struct packed {
		logic [31:0] sum;
		logic [17:0] row;
		logic        last;
	} result_t;

	// Round to nearest even and pack; a mantissa carry moves into the exponent field.
	function automatic logic [31:0] pack_round(logic sign, logic [7:0] ef, logic [23:0] man,
			logic g, logic s);
		logic        inc;
		logic [30:0] mag;
		inc = g & (s | man[0]);
		mag = {ef, man[22:0]} + {30'd0, inc};
		return {sign, mag};
	endfunction

	// Leading zero count of a 48-bit word.
	function automatic logic [5:0] lzc48(logic [47:0] v);
		logic [5:0] n;
		logic       hit;
		n = 6'd0;
		hit = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!hit && v[i]) begin
				hit = 1'b1;
				n = 6'(47 - i);
			end
		end
		return n;
	endfunction

	// Leading zero count of a 27-bit word.
	function automatic logic [4:0] lzc27(logic [26:0] v);
		logic [4:0] n;
		logic       hit;
		n = 5'd0;
		hit = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!hit && v[i]) begin
				hit = 1'b1;
				n = 5'(26 - i);
			end
		end
		return n;
	endfunction

	// IEEE single precision add with round to nearest even; NaN results are the quiet NaN.
	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [31:0] x, y, res;
		logic [7:0]  ex, ey, d;
		logic [23:0] mx, my;
		logic [26:0] bx, by, bys, mask;
		logic        st, sub, a_nan, b_nan, a_inf, b_inf;
		logic [27:0] r28;
		logic [26:0] r27;
		logic [4:0]  lz, sh;
		logic [8:0]  e;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		res = 32'd0;
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
			res = QUIET_NAN;
		end else if (a_inf) begin
			res = a;
		end else if (b_inf) begin
			res = b;
		end else begin
			// Larger magnitude first.
			if (a[30:0] < b[30:0]) begin
				x = b;
				y = a;
			end else begin
				x = a;
				y = b;
			end
			ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
			ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
			mx = {x[30:23] != 8'd0, x[22:0]};
			my = {y[30:23] != 8'd0, y[22:0]};
			d = ex - ey;
			bx = {mx, 3'b000};
			by = {my, 3'b000};
			// Align the smaller operand, folding lost bits into a sticky bit.
			if (d >= 8'd27) begin
				bys = 27'd0;
				st = |my;
			end else begin
				mask = (27'd1 << d[4:0]) - 27'd1;
				bys = by >> d[4:0];
				st = |(by & mask);
			end
			bys[0] = bys[0] | st;
			sub = x[31] ^ y[31];
			if (sub) begin
				r28 = {1'b0, bx} - {1'b0, bys};
			end else begin
				r28 = {1'b0, bx} + {1'b0, bys};
			end
			if (r28 == 28'd0) begin
				res = {sub ? 1'b0 : x[31], 31'd0};
			end else begin
				if (r28[27]) begin
					r27 = {r28[27:2], r28[1] | r28[0]};
					e = {1'b0, ex} + 9'd1;
				end else begin
					lz = lzc27(r28[26:0]);
					// Do not shift below the smallest exponent.
					sh = ({3'b000, lz} > (ex - 8'd1)) ? 5'(ex - 8'd1) : lz;
					r27 = r28[26:0] << sh;
					e = {1'b0, ex} - {4'd0, sh};
					if (!r27[26]) begin
						e = 9'd0;
					end
				end
				if (e >= 9'd255) begin
					res = {x[31], 8'hFF, 23'd0};
				end else begin
					res = pack_round(x[31], e[7:0], r27[26:3], r27[2], |r27[1:0]);
				end
			end
		end
		return res;
	endfunction

endpackage

>>> hdl/bmv_in_if.sv
// Input channel: vector loads and weight beats.
interface bmv_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] vector_value;
	logic [12:0] vector_index;
	logic [15:0] weight_bits;

	modport source (output valid, cmd, vector_value, vector_index, weight_bits, input ready);
	modport sink (input valid, cmd, vector_value, vector_index, weight_bits, output ready);
endinterface

>>> hdl/bmv_out_if.sv
// Output channel: finished row sums.
interface bmv_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] row_sum;
	logic [17:0] row_number;
	logic        last_row;

	modport source (output valid, row_sum, row_number, last_row, input ready);
	modport sink (input valid, row_sum, row_number, last_row, output ready);
endinterface

>>> hdl/bmv_cfg_if.sv
// Configuration write channel.
interface bmv_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/bmv_fmul.sv
// Three-stage fp32 multiplier with round to nearest even and subnormal support.
module bmv_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] prod
);

	logic        v_s2, v_s3, v_s4;
	logic [47:0] m_s2;
	logic [8:0]  esum_s2;
	logic        sign_s2, nan_s2, inf_s2, zero_s2;
	logic [47:0] mn_s3;
	logic [9:0]  er_s3;
	logic        sign_s3, nan_s3, inf_s3, zero_s3;
	logic [31:0] prod_s4;

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [7:0]  ea, eb;
	logic [5:0]  lz;
	logic [8:0]  dsh;
	logic [47:0] t, mask;
	logic        lost;
	logic [31:0] p_next;

	// Operand classification.
	always_comb begin
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
	end

	// Stage 2: mantissa product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		m_s2 <= ma * mb;
		esum_s2 <= {1'b0, ea} + {1'b0, eb};
		sign_s2 <= a[31] ^ b[31];
		nan_s2 <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
		inf_s2 <= a_inf || b_inf;
		zero_s2 <= a_zero || b_zero;
	end

	// Stage 3: normalize the product to a leading one at the top bit.
	assign lz = bmv_pkg::lzc48(m_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mn_s3 <= m_s2 << lz;
		er_s3 <= {1'b0, esum_s2} - 10'd126 - {4'd0, lz};
		sign_s3 <= sign_s2;
		nan_s3 <= nan_s2;
		inf_s3 <= inf_s2;
		zero_s3 <= zero_s2 || (m_s2 == 48'd0);
	end

	// Stage 4: denormalize if needed, round and pack.
	always_comb begin
		dsh = 9'(10'd1 - er_s3);
		t = mn_s3;
		lost = 1'b0;
		mask = 48'd0;
		p_next = 32'd0;
		if (nan_s3) begin
			p_next = bmv_pkg::QUIET_NAN;
		end else if (inf_s3) begin
			p_next = {sign_s3, 8'hFF, 23'd0};
		end else if (zero_s3) begin
			p_next = {sign_s3, 31'd0};
		end else if (!er_s3[9] && (er_s3 >= 10'd255)) begin
			p_next = {sign_s3, 8'hFF, 23'd0};
		end else if (!er_s3[9] && (er_s3 != 10'd0)) begin
			p_next = bmv_pkg::pack_round(sign_s3, er_s3[7:0], mn_s3[47:24], mn_s3[23],
				|mn_s3[22:0]);
		end else begin
			if (dsh >= 9'd48) begin
				t = 48'd0;
				lost = |mn_s3;
			end else begin
				mask = (48'd1 << dsh[5:0]) - 48'd1;
				t = mn_s3 >> dsh[5:0];
				lost = |(mn_s3 & mask);
			end
			p_next = bmv_pkg::pack_round(sign_s3, 8'd0, t[47:24], t[23], (|t[22:0]) | lost);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= p_next;
	end

	assign out_valid = v_s4;
	assign prod = prod_s4;

endmodule

>>> hdl/bf16_matrix_vector_rows_unit.sv
// Top level of the bf16 weight matrix times fp32 vector row unit.
//
// Load beats write one fp32 vector element into an on-chip store of MAX_VECTOR_LEN words and
// restart the matrix at row zero; weight beats are taken one per cycle while input is not held
// off, each bf16 weight is widened, multiplied by the stored element of its column and added to
// the row sum. Weights stream back to back. The store is read at the edge that accepts a
// weight; the product passes the multiplier stages, and the fp32 accumulate that closes the
// row-sum loop writes a row's sum straight into the result queue when its last product arrives.
// The queue holds eight results; input is held off only when the queue plus the row ends still
// in the pipeline would fill it. The store has no reset and needs no clearing pass.
module bf16_matrix_vector_rows_unit #(
	parameter int MAX_VECTOR_LEN = 8192
) (
	input  logic     clk,
	input  logic     arst_n,
	bmv_in_if.sink   in_ch,
	bmv_out_if.source out_ch,
	bmv_cfg_if.sink  cfg_ch
);

	localparam int          AW      = $clog2(MAX_VECTOR_LEN);
	localparam logic [16:0] MAX_LEN = 17'(MAX_VECTOR_LEN);

	logic [31:0] vstore [MAX_VECTOR_LEN];

	logic [13:0] row_length_q;
	logic [18:0] row_count_q;
	logic [12:0] col_q;
	logic [17:0] row_q;
	logic        first_q;
	logic [31:0] acc_q;

	logic        in_acc, is_load, is_weight, wr_en;
	logic [16:0] len_eff, col_clamp;
	logic [18:0] cnt_eff;
	logic        row_end, last;
	logic [AW-1:0] rd_addr, wr_addr;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] x_s1, w_s1;
	bmv_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_now;

	logic        p_valid;
	logic [31:0] p_s4, sum_next;

	bmv_pkg::result_t fifo_q [bmv_pkg::FIFO_DEPTH];
	logic [bmv_pkg::FIFO_AW-1:0] wp_q, rp_q;
	logic [bmv_pkg::FIFO_AW:0]   fcnt_q;
	logic [2:0]  pend;
	logic        push, pop;

	// Configuration registers; writes are always taken.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= bmv_pkg::ROW_LENGTH_RESET;
			row_count_q <= bmv_pkg::ROW_COUNT_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				bmv_pkg::REG_ROW_LENGTH: row_length_q <= cfg_ch.data[13:0];
				bmv_pkg::REG_ROW_COUNT:  row_count_q <= cfg_ch.data[18:0];
				default: ;
			endcase
		end
	end

	// Effective lengths, row end and last-row decisions at accept time.
	always_comb begin
		if (row_length_q == 14'd0) begin
			len_eff = 17'd1;
		end else if ({3'b000, row_length_q} > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = {3'b000, row_length_q};
		end
		if (row_count_q == 19'd0) begin
			cnt_eff = 19'd1;
		end else if (row_count_q > bmv_pkg::ROW_COUNT_MAX) begin
			cnt_eff = bmv_pkg::ROW_COUNT_MAX;
		end else begin
			cnt_eff = row_count_q;
		end
		row_end = ({4'd0, col_q} + 17'd1) >= len_eff;
		last = ({1'b0, row_q} + 19'd1) >= cnt_eff;
		col_clamp = ({4'd0, col_q} >= MAX_LEN) ? (MAX_LEN - 17'd1) : {4'd0, col_q};
		rd_addr = col_clamp[AW-1:0];
		wr_addr = AW'({4'd0, in_ch.vector_index});
		tag_now.first = first_q;
		tag_now.row_end = row_end;
		tag_now.last = last;
		tag_now.row = row_q;
	end

	assign in_acc = in_ch.valid && in_ch.ready;
	assign is_load = in_acc && (in_ch.cmd == bmv_pkg::CMD_LOAD);
	assign is_weight = in_acc && (in_ch.cmd == bmv_pkg::CMD_WEIGHT);
	assign wr_en = is_load && ({4'd0, in_ch.vector_index} < MAX_LEN);

	// Column, row and row-start tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 13'd0;
			row_q <= 18'd0;
			first_q <= 1'b1;
		end else if (is_load) begin
			col_q <= 13'd0;
			row_q <= 18'd0;
			first_q <= 1'b1;
		end else if (is_weight) begin
			if (row_end) begin
				col_q <= 13'd0;
				row_q <= last ? 18'd0 : row_q + 18'd1;
				first_q <= 1'b1;
			end else begin
				col_q <= col_q + 13'd1;
				first_q <= 1'b0;
			end
		end
	end

	// Vector store: written by loads, read once per weight.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vstore[wr_addr] <= in_ch.vector_value;
		end
		if (is_weight) begin
			x_s1 <= vstore[rd_addr];
		end
	end

	// Stage 1 payload and tags.
	always_ff @(posedge clk) begin
		w_s1 <= {in_ch.weight_bits, bmv_pkg::WIDEN_SHIFT'(0)};
		tag_s1 <= tag_now;
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		tag_s4 <= tag_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= is_weight;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	bmv_fmul u_fmul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.a        (w_s1),
		.b        (x_s1),
		.out_valid(p_valid),
		.prod     (p_s4)
	);

	// Row-sum accumulate; a row start adds onto positive zero.
	assign sum_next = bmv_pkg::fp_add(tag_s4.first ? 32'd0 : acc_q, p_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
		end else if (p_valid) begin
			acc_q <= sum_next;
		end
	end

	// Result queue with room reserved for row ends still in flight.
	assign push = p_valid && tag_s4.row_end;
	assign pop = out_ch.valid && out_ch.ready;
	assign pend = {2'b00, v_s1 && tag_s1.row_end} + {2'b00, v_s2 && tag_s2.row_end}
		+ {2'b00, v_s3 && tag_s3.row_end} + {2'b00, v_s4 && tag_s4.row_end};
	assign in_ch.ready = ({1'b0, fcnt_q} + {2'b00, pend}) < 5'(bmv_pkg::FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{sum: sum_next, row: tag_s4.row, last: tag_s4.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10: fcnt_q <= fcnt_q + 1'b1;
				2'b01: fcnt_q <= fcnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign out_ch.valid = (fcnt_q != '0);
	assign out_ch.row_sum = fifo_q[rp_q].sum;
	assign out_ch.row_number = fifo_q[rp_q].row;
	assign out_ch.last_row = fifo_q[rp_q].last;

	// The queue never overflows.
	assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= 4'(bmv_pkg::FIFO_DEPTH))
		else $error("result queue over capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fcnt_q < 4'(bmv_pkg::FIFO_DEPTH))
		else $error("result pushed into a full queue");

	// A load restarts the row so the next weight adds onto zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		is_load |=> first_q && col_q == 13'd0 && row_q == 18'd0)
		else $error("load did not restart the matrix");

	// Multiplier output lines up with the tag pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		p_valid == v_s4)
		else $error("multiplier and tag pipeline out of step");

endmodule
